### rtl/core/same_padded_strided_conv2d_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the convolution unit
// Each macro checks on the rising clock edge and is quiet while reset is held.
// ---------------------------------------------------------------------------
`ifndef SAME_PADDED_STRIDED_CONV2D_UNIT_ASSERT_SVH
`define SAME_PADDED_STRIDED_CONV2D_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CNV2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("conv2d assertion failed");

// Next-cycle implication.
`define CNV2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("conv2d assertion failed");

`endif

### rtl/core/cnv2d_pkg.sv
// ---------------------------------------------------------------------------
// cnv2d_pkg
// Types and constants shared by the strided SAME-padded convolution unit.
// ---------------------------------------------------------------------------
package cnv2d_pkg;

    localparam int FEAT_MAX    = 64;
    localparam int KERN_MAX    = 8;
    localparam int SLOT_BITS   = 3;
    localparam int COL_BITS    = 6;
    localparam int KIDX_BITS   = 3;
    localparam int LINE_AW     = SLOT_BITS + COL_BITS;
    localparam int COEF_AW     = 2 * KIDX_BITS;
    localparam int SAMPLE_BITS = 16;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int ACC_BITS    = 40;

    localparam logic [1:0] KIND_COEF   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_DRAIN  = 2'd2;

    localparam logic [2:0] CFG_N_FEATURES  = 3'd0;
    localparam logic [2:0] CFG_KERNEL_ROWS = 3'd1;
    localparam logic [2:0] CFG_KERNEL_COLS = 3'd2;
    localparam logic [2:0] CFG_STRIDE      = 3'd3;
    localparam logic [2:0] CFG_SHIFT       = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [15:0] data_value;
        logic [2:0]        coef_row;
        logic [2:0]        coef_col;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic [15:0]       out_row;
        logic [5:0]        out_col;
        logic              row_last;
        logic              frame_last;
        logic              saturated;
    } result_t;

    // One multiply-accumulate term travelling down the datapath.
    typedef struct packed {
        logic valid;
        logic mask;
        logic first;
        logic last;
    } term_t;

endpackage

### rtl/core/cnv2d_store.sv
// ---------------------------------------------------------------------------
// cnv2d_store
// Line memory and coefficient memory, one write and one registered read each.
// ---------------------------------------------------------------------------
module cnv2d_store (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   line_we,
    input  logic [cnv2d_pkg::LINE_AW-1:0]          line_waddr,
    input  logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] line_wdata,
    input  logic                                   coef_we,
    input  logic [cnv2d_pkg::COEF_AW-1:0]          coef_waddr,
    input  logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] coef_wdata,
    input  cnv2d_pkg::term_t                       term_in,
    input  logic [cnv2d_pkg::LINE_AW-1:0]          line_raddr,
    input  logic [cnv2d_pkg::COEF_AW-1:0]          coef_raddr,
    output cnv2d_pkg::term_t                       term_out,
    output logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] line_rdata,
    output logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] coef_rdata
);

    logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] line_mem [2**cnv2d_pkg::LINE_AW];
    logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] coef_mem [2**cnv2d_pkg::COEF_AW];
    logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] line_rdata_reg;
    logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] coef_rdata_reg;
    cnv2d_pkg::term_t                         term_reg;

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (term_in.valid)
        begin
            line_rdata_reg <= line_mem[line_raddr];
            coef_rdata_reg <= coef_mem[coef_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
        end
        else
        begin
            term_reg <= term_in;
        end
    end

    assign term_out   = term_reg;
    assign line_rdata = line_rdata_reg;
    assign coef_rdata = coef_rdata_reg;

endmodule

### rtl/core/cnv2d_mac.sv
// ---------------------------------------------------------------------------
// cnv2d_mac
// Registered multiply followed by an accumulator that restarts on a first term.
// ---------------------------------------------------------------------------
module cnv2d_mac (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cnv2d_pkg::term_t                         term,
    input  logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] line_data,
    input  logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] coef_data,
    output logic signed [cnv2d_pkg::ACC_BITS-1:0]    acc,
    output logic                                     done
);

    logic signed [cnv2d_pkg::PROD_BITS-1:0] prod_reg;
    logic signed [cnv2d_pkg::ACC_BITS-1:0]  acc_reg;
    cnv2d_pkg::term_t                       ptag_reg;
    logic                                   done_reg;

    always_ff @(posedge clk)
    begin
        if (term.valid)
        begin
            // Terms that fall into padding contribute nothing.
            if (term.mask)
            begin
                prod_reg <= line_data * coef_data;
            end
            else
            begin
                prod_reg <= '0;
            end
        end
        if (ptag_reg.valid)
        begin
            if (ptag_reg.first)
            begin
                acc_reg <= cnv2d_pkg::ACC_BITS'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + cnv2d_pkg::ACC_BITS'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptag_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ptag_reg <= term;
            done_reg <= ptag_reg.valid & ptag_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### rtl/core/same_padded_strided_conv2d_unit.sv
// Sequence: a coefficient or a sample that completes no row is stored in S_IDLE, which stays ready.
// A releasing item first walks S_PREP to the last output column to find the right padding,
// then per output runs S_RUN, S_WAIT and S_PUT: one MAC term per line memory read.
// Throughput: one item at a time; results leave through a one-entry output register.
// Reset: configuration returns to its defaults and all counters clear; the line and
// coefficient memories are not cleared.
`include "same_padded_strided_conv2d_unit_assert.svh"

// ---------------------------------------------------------------------------
// same_padded_strided_conv2d_unit
// Streaming 2-D convolution with SAME zero padding and a feature stride.
// ---------------------------------------------------------------------------
module same_padded_strided_conv2d_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  cnv2d_pkg::sample_t sample,
    output logic               result_valid,
    input  logic               result_stall,
    output cnv2d_pkg::result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_RUN, S_WAIT, S_PUT} state_t;

    state_t       state_reg;
    logic [6:0]   n_features_reg;
    logic [3:0]   kernel_rows_reg;
    logic [3:0]   kernel_cols_reg;
    logic [3:0]   stride_reg;
    logic [4:0]   shift_reg;
    logic [5:0]   col_cnt_reg;
    logic [2:0]   head_reg;
    logic [15:0]  pending_reg;
    logic [3:0]   behind_reg;
    logic [15:0]  out_row_reg;
    logic [15:0]  e_pend_reg;
    logic [3:0]   e_behind_reg;
    logic [2:0]   e_head_reg;
    logic [15:0]  e_row_reg;
    logic         e_final_reg;
    logic [6:0]   base_reg;
    logic [2:0]   left_reg;
    logic [2:0]   k_reg;
    logic [2:0]   l_reg;
    logic [5:0]   j_reg;
    cnv2d_pkg::result_t res_reg;
    logic         res_valid_reg;

    logic [6:0]   nf;
    logic [3:0]   kr;
    logic [3:0]   kc;
    logic [3:0]   st;
    logic [2:0]   kr_m1;
    logic [2:0]   kc_m1;
    logic [2:0]   top;
    logic [2:0]   bottom;
    logic         in_acc;
    logic         row_done;
    logic [15:0]  pend_inc;
    logic [3:0]   behind_inc;
    logic         j_last;
    logic signed [8:0]  padw;
    logic [2:0]   left_calc;
    logic         row_ok;
    logic signed [17:0] row_dist;
    logic         dist_ok;
    logic [2:0]   slot;
    logic signed [8:0]  col;
    logic         col_ok;
    logic         put_ok;

    cnv2d_pkg::term_t term_issue;
    cnv2d_pkg::term_t term_rd;
    logic [cnv2d_pkg::LINE_AW-1:0] line_raddr;
    logic [cnv2d_pkg::COEF_AW-1:0] coef_raddr;
    logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] line_rdata;
    logic signed [cnv2d_pkg::SAMPLE_BITS-1:0] coef_rdata;
    logic signed [cnv2d_pkg::ACC_BITS-1:0] acc;
    logic         mac_done;
    logic         line_we;
    logic         coef_we;

    logic signed [cnv2d_pkg::ACC_BITS:0] rnd;
    logic signed [cnv2d_pkg::ACC_BITS:0] rsum;
    logic signed [cnv2d_pkg::ACC_BITS:0] rshift;
    logic         sat_hi;
    logic         sat_lo;
    logic signed [15:0] out_val;

    // Out-of-range register values act as the nearest legal value.
    assign nf = (n_features_reg == 7'd0) ? 7'd1 :
                (n_features_reg > 7'(cnv2d_pkg::FEAT_MAX)) ? 7'(cnv2d_pkg::FEAT_MAX) :
                n_features_reg;
    assign kr = (kernel_rows_reg == 4'd0) ? 4'd1 :
                (kernel_rows_reg > 4'(cnv2d_pkg::KERN_MAX)) ? 4'(cnv2d_pkg::KERN_MAX) :
                kernel_rows_reg;
    assign kc = (kernel_cols_reg == 4'd0) ? 4'd1 :
                (kernel_cols_reg > 4'(cnv2d_pkg::KERN_MAX)) ? 4'(cnv2d_pkg::KERN_MAX) :
                kernel_cols_reg;
    assign st     = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
    assign kr_m1  = 3'(kr - 4'd1);
    assign kc_m1  = 3'(kc - 4'd1);
    assign top    = kr_m1 >> 1;
    assign bottom = kr_m1 - top;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != S_IDLE);
    assign in_acc       = sample_valid && (state_reg == S_IDLE);

    assign row_done   = (7'({1'b0, col_cnt_reg}) + 7'd1) >= nf;
    assign pend_inc   = (pending_reg == 16'hFFFF) ? 16'hFFFF : pending_reg + 16'd1;
    assign behind_inc = (behind_reg < 4'(cnv2d_pkg::KERN_MAX)) ? behind_reg + 4'd1 : behind_reg;
    assign j_last     = (8'({1'b0, base_reg}) + 8'({4'd0, st})) >= 8'({1'b0, nf});

    assign padw      = $signed({2'b0, base_reg}) + $signed({5'b0, kc}) - $signed({2'b0, nf});
    assign left_calc = (padw > 9'sd0) ? padw[3:1] : 3'd0;

    // Row and column selection for the term at (k, l) of output column j.
    assign row_ok   = (k_reg < top) ? ({1'b0, top - k_reg} <= e_behind_reg)
                                    : ({13'd0, k_reg - top} < e_pend_reg);
    assign row_dist = $signed({2'b0, e_pend_reg}) + $signed({15'd0, top})
                    - $signed({15'd0, k_reg}) - 18'sd1;
    assign dist_ok  = (row_dist >= 18'sd0) && (row_dist <= 18'sd7);
    assign slot     = e_head_reg - 3'd1 - row_dist[2:0];
    assign col      = $signed({2'b0, base_reg}) + $signed({6'd0, l_reg})
                    - $signed({6'd0, left_reg});
    assign col_ok   = (col >= 9'sd0) && (col < $signed({2'b0, nf}));

    assign term_issue.valid = (state_reg == S_RUN);
    assign term_issue.mask  = row_ok && dist_ok && col_ok;
    assign term_issue.first = (k_reg == 3'd0) && (l_reg == 3'd0);
    assign term_issue.last  = (k_reg == kr_m1) && (l_reg == kc_m1);
    assign line_raddr       = {slot, col[5:0]};
    assign coef_raddr       = {k_reg, l_reg};

    assign line_we = in_acc && (sample.kind == cnv2d_pkg::KIND_SAMPLE);
    assign coef_we = in_acc && (sample.kind == cnv2d_pkg::KIND_COEF);

    cnv2d_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_we    (line_we),
        .line_waddr ({head_reg, col_cnt_reg}),
        .line_wdata (sample.data_value),
        .coef_we    (coef_we),
        .coef_waddr ({sample.coef_row, sample.coef_col}),
        .coef_wdata (sample.data_value),
        .term_in    (term_issue),
        .line_raddr (line_raddr),
        .coef_raddr (coef_raddr),
        .term_out   (term_rd),
        .line_rdata (line_rdata),
        .coef_rdata (coef_rdata)
    );

    cnv2d_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .term      (term_rd),
        .line_data (line_rdata),
        .coef_data (coef_rdata),
        .acc       (acc),
        .done      (mac_done)
    );

    // Round half up, floor shift, then saturate.
    assign rnd    = (shift_reg == 5'd0) ? '0
                  : (cnv2d_pkg::ACC_BITS+1)'(1) << (shift_reg - 5'd1);
    assign rsum   = (cnv2d_pkg::ACC_BITS+1)'(acc) + rnd;
    assign rshift = rsum >>> shift_reg;
    assign sat_hi = rshift > (cnv2d_pkg::ACC_BITS+1)'(32767);
    assign sat_lo = rshift < -(cnv2d_pkg::ACC_BITS+1)'(32768);
    assign out_val = sat_hi ? 16'sh7FFF : sat_lo ? 16'sh8000 : rshift[15:0];

    assign put_ok = !res_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            n_features_reg  <= 7'd64;
            kernel_rows_reg <= 4'd3;
            kernel_cols_reg <= 4'd3;
            stride_reg      <= 4'd1;
            shift_reg       <= 5'd15;
            col_cnt_reg     <= '0;
            head_reg        <= '0;
            pending_reg     <= '0;
            behind_reg      <= '0;
            out_row_reg     <= '0;
            e_pend_reg      <= '0;
            e_behind_reg    <= '0;
            e_head_reg      <= '0;
            e_row_reg       <= '0;
            e_final_reg     <= 1'b0;
            base_reg        <= '0;
            left_reg        <= '0;
            k_reg           <= '0;
            l_reg           <= '0;
            j_reg           <= '0;
            res_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    cnv2d_pkg::CFG_N_FEATURES:  n_features_reg  <= cfg_data[6:0];
                    cnv2d_pkg::CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[3:0];
                    cnv2d_pkg::CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[3:0];
                    cnv2d_pkg::CFG_STRIDE:      stride_reg      <= cfg_data[3:0];
                    cnv2d_pkg::CFG_SHIFT:       shift_reg       <= cfg_data[4:0];
                    default: ;
                endcase
            end

            // In S_PUT a free output register is reloaded below instead.
            if (res_valid_reg && !result_stall && (state_reg != S_PUT))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (sample.kind)
                            cnv2d_pkg::KIND_SAMPLE:
                            begin
                                if (row_done)
                                begin
                                    col_cnt_reg <= '0;
                                    head_reg    <= head_reg + 3'd1;
                                    if (pend_inc > {13'd0, bottom})
                                    begin
                                        e_pend_reg   <= pend_inc;
                                        e_behind_reg <= behind_reg;
                                        e_head_reg   <= head_reg + 3'd1;
                                        e_row_reg    <= out_row_reg;
                                        e_final_reg  <= 1'b0;
                                        pending_reg  <= pend_inc - 16'd1;
                                        behind_reg   <= behind_inc;
                                        out_row_reg  <= out_row_reg + 16'd1;
                                        base_reg     <= '0;
                                        state_reg    <= S_PREP;
                                    end
                                    else
                                    begin
                                        pending_reg <= pend_inc;
                                    end
                                end
                                else
                                begin
                                    col_cnt_reg <= col_cnt_reg + 6'd1;
                                end
                            end
                            cnv2d_pkg::KIND_DRAIN:
                            begin
                                col_cnt_reg <= '0;
                                if (pending_reg != 16'd0)
                                begin
                                    e_pend_reg   <= pending_reg;
                                    e_behind_reg <= behind_reg;
                                    e_head_reg   <= head_reg;
                                    e_row_reg    <= out_row_reg;
                                    e_final_reg  <= (pending_reg == 16'd1);
                                    base_reg     <= '0;
                                    state_reg    <= S_PREP;
                                end
                                // The last pending row closes the frame.
                                if (pending_reg <= 16'd1)
                                begin
                                    pending_reg <= '0;
                                    behind_reg  <= '0;
                                    out_row_reg <= '0;
                                end
                                else
                                begin
                                    pending_reg <= pending_reg - 16'd1;
                                    behind_reg  <= behind_inc;
                                    out_row_reg <= out_row_reg + 16'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PREP:
                begin
                    // Walk to the last output column to size the left padding.
                    if (j_last)
                    begin
                        left_reg  <= left_calc;
                        base_reg  <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        l_reg     <= '0;
                        state_reg <= S_RUN;
                    end
                    else
                    begin
                        base_reg <= base_reg + 7'({3'd0, st});
                    end
                end
                S_RUN:
                begin
                    if (l_reg == kc_m1)
                    begin
                        l_reg <= '0;
                        if (k_reg == kr_m1)
                        begin
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        l_reg <= l_reg + 3'd1;
                    end
                end
                S_WAIT:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (put_ok)
                    begin
                        res_reg.out_value  <= out_val;
                        res_reg.out_row    <= e_row_reg;
                        res_reg.out_col    <= j_reg;
                        res_reg.row_last   <= j_last;
                        res_reg.frame_last <= e_final_reg && j_last;
                        res_reg.saturated  <= sat_hi || sat_lo;
                        res_valid_reg      <= 1'b1;
                        if (j_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 6'd1;
                            base_reg  <= base_reg + 7'({3'd0, st});
                            k_reg     <= '0;
                            l_reg     <= '0;
                            state_reg <= S_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `CNV2D_ASSERT_NOW(a_done_in_wait, mac_done, state_reg == S_WAIT)
    `CNV2D_ASSERT_NEXT(a_wait_to_put, (state_reg == S_WAIT) && mac_done, state_reg == S_PUT)
    `CNV2D_ASSERT_NOW(a_frame_last_row, result_valid && result.frame_last, result.row_last)
    `CNV2D_ASSERT_NEXT(a_put_loads, (state_reg == S_PUT) && !res_valid_reg, res_valid_reg)

endmodule
